>>> design/nearest_neighbor_image_scaler_core_defines.svh
// ----------------------------------------------------------------------------
// Scaler assertion macros
// Shared assertion wrappers, clocked on clk_i.
// ----------------------------------------------------------------------------
`ifndef NEAREST_NEIGHBOR_IMAGE_SCALER_CORE_DEFINES_SVH
`define NEAREST_NEIGHBOR_IMAGE_SCALER_CORE_DEFINES_SVH

// checked out of reset only
`define NNIS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked during reset as well
`define NNIS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> design/nnis_pkg.sv
// ----------------------------------------------------------------------------
// Scaler package
// Field widths, register indexes, reset values and shared types.
// ----------------------------------------------------------------------------
package nnis_pkg;

  localparam int unsigned CFG_W     = 11;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned PIX_W     = 8;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_W = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_H = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DST_W = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DST_H = 2'd3;

  localparam logic [CFG_W-1:0] RST_SRC_W = 11'd640;
  localparam logic [CFG_W-1:0] RST_SRC_H = 11'd480;
  localparam logic [CFG_W-1:0] RST_DST_W = 11'd640;
  localparam logic [CFG_W-1:0] RST_DST_H = 11'd480;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_EMIT = 1'b1;

  // effective frame sizes, always 1 .. max
  typedef struct packed {
    logic [CFG_W-1:0] src_w;
    logic [CFG_W-1:0] src_h;
    logic [CFG_W-1:0] dst_w;
    logic [CFG_W-1:0] dst_h;
  } nnis_size_t;

endpackage

>>> design/nnis_fifo.sv
// ----------------------------------------------------------------------------
// Scaler word queue
// Small first-in first-out buffer between the scaler stages.
// ----------------------------------------------------------------------------
module nnis_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> design/nnis_div.sv
// ----------------------------------------------------------------------------
// Scaler divider
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module nnis_div #(
  parameter int unsigned NW = 21,
  parameter int unsigned DW = 11
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          busy_o,
  output logic [NW-1:0] quot_o
);

  localparam int unsigned CNT_W = $clog2(NW);

  logic             busy_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DW-1:0]    rem_q, den_q;
  logic [NW-1:0]    quot_q;
  logic [DW:0]      rem_sh, diff;
  logic             ge;

  assign rem_sh = {rem_q, quot_q[NW-1]};
  assign ge     = (rem_sh >= {1'b0, den_q});
  assign diff   = rem_sh - {1'b0, den_q};
  assign busy_o = busy_q;
  assign quot_o = quot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      if (cnt_q == CNT_W'(NW - 1)) begin
        busy_q <= 1'b0;
      end
      cnt_q <= cnt_q + 1'b1;
    end
  end

  // remainder stays below the divisor, so DW bits hold it
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= '0;
      quot_q <= num_i;
      den_q  <= den_i;
    end else if (busy_q) begin
      rem_q  <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
      quot_q <= {quot_q[NW-2:0], ge};
    end
  end

endmodule

>>> design/nnis_front.sv
// ----------------------------------------------------------------------------
// Scaler front end
// Accepts words, keeps the load and emit raster counters, tags each word
// with its coordinates and queues it for the back end.
// ----------------------------------------------------------------------------
module nnis_front #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024,
  localparam int unsigned CW    = $clog2(MAX_WIDTH),
  localparam int unsigned RW    = $clog2(MAX_HEIGHT),
  localparam int unsigned CMD_W = 2 + nnis_pkg::PIX_W + CW + RW
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic                       kind_i,
  input  logic [nnis_pkg::PIX_W-1:0] pixel_in_i,
  input  nnis_pkg::nnis_size_t       size_i,
  input  logic                       cmd_full_i,
  output logic                       cmd_push_o,
  output logic [CMD_W-1:0]           cmd_o
);

  import nnis_pkg::*;

  logic [CW-1:0] ld_col_q, ld_col_d, em_col_q, em_col_d;
  logic [RW-1:0] ld_row_q, ld_row_d, em_row_q, em_row_d;
  logic          accept, ld_col_end, ld_row_end, em_col_end, em_row_end, last;

  assign accept     = push_i && !cmd_full_i;
  assign cmd_push_o = accept;

  assign ld_col_end = (32'(ld_col_q) + 32'd1 >= 32'(size_i.src_w));
  assign ld_row_end = (32'(ld_row_q) + 32'd1 >= 32'(size_i.src_h));
  assign em_col_end = (32'(em_col_q) + 32'd1 >= 32'(size_i.dst_w));
  assign em_row_end = (32'(em_row_q) + 32'd1 >= 32'(size_i.dst_h));
  assign last       = em_col_end && em_row_end;

  assign cmd_o = (kind_i == KIND_LOAD) ? {kind_i, pixel_in_i, ld_col_q, ld_row_q, 1'b0}
                                       : {kind_i, pixel_in_i, em_col_q, em_row_q, last};

  always_comb begin
    ld_col_d = ld_col_q;
    ld_row_d = ld_row_q;
    em_col_d = em_col_q;
    em_row_d = em_row_q;
    if (accept) begin
      if (kind_i == KIND_LOAD) begin
        ld_col_d = ld_col_end ? '0 : ld_col_q + 1'b1;
        if (ld_col_end) begin
          ld_row_d = ld_row_end ? '0 : ld_row_q + 1'b1;
        end
      end else begin
        em_col_d = em_col_end ? '0 : em_col_q + 1'b1;
        if (em_col_end) begin
          em_row_d = em_row_end ? '0 : em_row_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ld_col_q <= '0;
      ld_row_q <= '0;
      em_col_q <= '0;
      em_row_q <= '0;
    end else begin
      ld_col_q <= ld_col_d;
      ld_row_q <= ld_row_d;
      em_col_q <= em_col_d;
      em_row_q <= em_row_d;
    end
  end

endmodule

>>> design/nnis_back.sv
// ----------------------------------------------------------------------------
// Scaler back end
// Writes loaded pixels to the frame store; for an emit, scales the
// coordinates with two serial dividers, reads the store and queues the word.
// ----------------------------------------------------------------------------
`include "nearest_neighbor_image_scaler_core_defines.svh"

module nnis_back #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024,
  localparam int unsigned CW    = $clog2(MAX_WIDTH),
  localparam int unsigned RW    = $clog2(MAX_HEIGHT),
  localparam int unsigned CMD_W = 2 + nnis_pkg::PIX_W + CW + RW,
  localparam int unsigned RES_W = nnis_pkg::PIX_W + 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cmd_empty_i,
  input  logic [CMD_W-1:0]     cmd_i,
  output logic                 cmd_pop_o,
  input  nnis_pkg::nnis_size_t size_i,
  input  logic                 res_full_i,
  output logic                 res_push_o,
  output logic [RES_W-1:0]     res_o
);

  import nnis_pkg::*;

  localparam int unsigned XW    = CW + CFG_W;
  localparam int unsigned YW    = RW + CFG_W;
  localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = $clog2(DEPTH);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_WAIT  = 3'd3;
  localparam logic [2:0] ST_SAT   = 3'd4;
  localparam logic [2:0] ST_READ  = 3'd5;
  localparam logic [2:0] ST_OUT   = 3'd6;

  logic [2:0]       state_q, state_d;
  logic             head_kind, head_last;
  logic [PIX_W-1:0] head_pix, pix_q;
  logic [CW-1:0]    head_col, col_q, sx_q;
  logic [RW-1:0]    head_row, row_q, sy_q;
  logic             last_q;
  logic [XW-1:0]    num_x_q, quot_x;
  logic [YW-1:0]    num_y_q, quot_y;
  logic             busy_x, busy_y, div_start, wr_en;
  logic [AW-1:0]    wr_addr, rd_addr;
  logic [PIX_W-1:0] mem [DEPTH];

  assign head_kind = cmd_i[CMD_W-1];
  assign head_pix  = cmd_i[CMD_W-2 -: PIX_W];
  assign head_col  = cmd_i[CW+RW:RW+1];
  assign head_row  = cmd_i[RW:1];
  assign head_last = cmd_i[0];

  assign wr_addr = AW'(32'(head_row) * 32'(MAX_WIDTH) + 32'(head_col));
  assign rd_addr = AW'(32'(sy_q) * 32'(MAX_WIDTH) + 32'(sx_q));
  assign res_o   = {pix_q, last_q};

  always_comb begin
    state_d    = state_q;
    cmd_pop_o  = 1'b0;
    wr_en      = 1'b0;
    div_start  = 1'b0;
    res_push_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          if (head_kind == KIND_LOAD) begin
            wr_en = 1'b1;
          end else begin
            state_d = ST_MUL;
          end
        end
      end
      ST_MUL: state_d = ST_DIV;
      ST_DIV: begin
        div_start = 1'b1;
        state_d   = ST_WAIT;
      end
      ST_WAIT: begin
        if (!busy_x && !busy_y) begin
          state_d = ST_SAT;
        end
      end
      ST_SAT:  state_d = ST_READ;
      ST_READ: state_d = ST_OUT;
      ST_OUT: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o && head_kind == KIND_EMIT) begin
      col_q  <= head_col;
      row_q  <= head_row;
      last_q <= head_last;
    end
    if (state_q == ST_MUL) begin
      num_x_q <= XW'(col_q) * XW'(size_i.src_w);
      num_y_q <= YW'(row_q) * YW'(size_i.src_h);
    end
    // clamp to the last source column and row
    if (state_q == ST_SAT) begin
      sx_q <= (quot_x >= XW'(size_i.src_w)) ? CW'(size_i.src_w - 1'b1) : CW'(quot_x);
      sy_q <= (quot_y >= YW'(size_i.src_h)) ? RW'(size_i.src_h - 1'b1) : RW'(quot_y);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= head_pix;
    end
    if (state_q == ST_READ) begin
      pix_q <= mem[rd_addr];
    end
  end

  nnis_div #(
    .NW (XW),
    .DW (CFG_W)
  ) u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_x_q),
    .den_i   (size_i.dst_w),
    .busy_o  (busy_x),
    .quot_o  (quot_x)
  );

  nnis_div #(
    .NW (YW),
    .DW (CFG_W)
  ) u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_y_q),
    .den_i   (size_i.dst_h),
    .busy_o  (busy_y),
    .quot_o  (quot_y)
  );

  `NNIS_ASSERT(a_div_started, state_q == ST_DIV |=> busy_x && busy_y, "dividers not started")
  `NNIS_ASSERT(a_sat_in_range, state_q == ST_SAT |=> (32'(sx_q) < 32'($past(size_i.src_w)) && 32'(sy_q) < 32'($past(size_i.src_h))), "source coordinate out of range")
  `NNIS_ASSERT(a_load_stays_idle, wr_en |=> state_q == ST_IDLE, "load left the idle state")
  `NNIS_ASSERT_ALWAYS(a_reset_idle, $rose(rst_ni) |-> state_q == ST_IDLE && !busy_x && !busy_y, "back end busy out of reset")

endmodule

>>> design/nearest_neighbor_image_scaler_core.sv
// ----------------------------------------------------------------------------
// Nearest-neighbour image scaler core
// A load word is written to the frame store from the back end's idle state. An
// emit word waits on the serial coordinate dividers before the store is read.
// Reset clears all counters and sets sizes to 640x480; frame store undefined.
// ----------------------------------------------------------------------------
module nearest_neighbor_image_scaler_core #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  output logic                           full,
  input  logic                           kind_i,
  input  logic [nnis_pkg::PIX_W-1:0]     pixel_in_i,
  output logic                           empty,
  input  logic                           pop,
  output logic [nnis_pkg::PIX_W-1:0]     pixel_out_o,
  output logic                           frame_last_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [nnis_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [nnis_pkg::CFG_W-1:0]     cfg_data_i
);

  import nnis_pkg::*;

  localparam int unsigned CW    = $clog2(MAX_WIDTH);
  localparam int unsigned RW    = $clog2(MAX_HEIGHT);
  localparam int unsigned CMD_W = 2 + PIX_W + CW + RW;
  localparam int unsigned RES_W = PIX_W + 1;

  logic [CFG_W-1:0] src_w_q, src_h_q, dst_w_q, dst_h_q;
  nnis_size_t       size;
  logic             cmd_push, cmd_full, cmd_pop, cmd_empty, res_push, res_full;
  logic [CMD_W-1:0] cmd_in, cmd_out;
  logic [RES_W-1:0] res_in, res_out;

  function automatic logic [CFG_W-1:0] eff_size(logic [CFG_W-1:0] v, int unsigned max_v);
    logic [CFG_W-1:0] r;
    if (v == '0) begin
      r = CFG_W'(1);
    end else if (32'(v) > max_v) begin
      r = CFG_W'(max_v);
    end else begin
      r = v;
    end
    return r;
  endfunction

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= RST_SRC_W;
      src_h_q <= RST_SRC_H;
      dst_w_q <= RST_DST_W;
      dst_h_q <= RST_DST_H;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_SRC_W: src_w_q <= cfg_data_i;
        REG_SRC_H: src_h_q <= cfg_data_i;
        REG_DST_W: dst_w_q <= cfg_data_i;
        REG_DST_H: dst_h_q <= cfg_data_i;
      endcase
    end
  end

  assign size.src_w = eff_size(src_w_q, MAX_WIDTH);
  assign size.src_h = eff_size(src_h_q, MAX_HEIGHT);
  assign size.dst_w = eff_size(dst_w_q, MAX_WIDTH);
  assign size.dst_h = eff_size(dst_h_q, MAX_HEIGHT);

  assign full = cmd_full;

  nnis_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .kind_i     (kind_i),
    .pixel_in_i (pixel_in_i),
    .size_i     (size),
    .cmd_full_i (cmd_full),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  nnis_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (2)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_out),
    .empty_o (cmd_empty)
  );

  nnis_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .size_i      (size),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  nnis_fifo #(
    .WIDTH (RES_W),
    .DEPTH (2)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty)
  );

  assign pixel_out_o  = res_out[RES_W-1:1];
  assign frame_last_o = res_out[0];

endmodule
